[sv/sacf_pkg.sv]
// Shared types and constants for the set-associative FIFO-replacement tag store.
// No dependencies; imported by sacf_cmp_unit, the top level and the bench.
package sacf_pkg;

    localparam int ADDR_W       = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int IDX_VAL_W    = 15;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 4'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_MOD,
        ST_SETRD,
        ST_SEARCH,
        ST_VICTIM,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_flags_t;

endpackage

[sv/sacf_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies; used for tag and set stores.
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sacf_cmp_unit.sv]
// Shared compare/subtract unit: set reduction steps and tag compares.
// Depends on sacf_pkg (cmp_flags_t).
module sacf_cmp_unit #(
    parameter int W = 32
) (
    input  logic [W-1:0]         a,
    input  logic [W-1:0]         b,
    output sacf_pkg::cmp_flags_t flags,
    output logic [W-1:0]         diff
);
    import sacf_pkg::*;

    logic [W:0] sub;

    assign sub      = {1'b0, a} - {1'b0, b};
    assign diff     = sub[W-1:0];
    assign flags.ge = ~sub[W];
    assign flags.eq = (a == b);

endmodule

[sv/set_assoc_cache_fifo_lookup_unit.sv]
// Top level of the set-associative tag store with FIFO replacement.
// Depends on sacf_pkg, sacf_ram (tag and set stores) and sacf_cmp_unit.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_ready   | address
//  out     | out_valid / out_ready | hit, set_number, way_number, evicted_valid,
//          |                       | evicted_line, hit_total, miss_total
//  cfg     | cfg_we                | cfg_index, cfg_data (no read-back)
//
// A word is shifted and reads its set state, then searches the ways in use
// (ways_in_use clamped to 1..MAX_WAYS) up to a hit; a miss then reads the victim
// and writes it. The tag store gives one way per cycle to the shared comparator.
// If MAX_SETS is not a power of two, set reduction is added: a reciprocal multiply
// gives the quotient, then the shared comparator subtracts quotient times MAX_SETS.
// After reset a clearing pass zeroes every entry of the set store; in_ready
// stays low during it. Tags need no clear: a way counts as valid only below its
// set's fill count. A finished word waits in the output register while the next
// address is taken; the lookup stalls in its last step only if that register is
// still full.
module set_assoc_cache_fifo_lookup_unit #(
    parameter int MAX_SETS = sacf_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sacf_pkg::MAX_WAYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sacf_pkg::ADDR_W-1:0]      address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [7:0]                       set_number,
    output logic [2:0]                       way_number,
    output logic                             evicted_valid,
    output logic [sacf_pkg::ADDR_W-1:0]      evicted_line,
    output logic [31:0]                      hit_total,
    output logic [31:0]                      miss_total,
    input  logic                             cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sacf_pkg::*;

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYC_W    = $clog2(MAX_WAYS + 1);
    localparam int SETW_W    = WAYC_W + WAY_W;
    localparam int TAG_DEPTH = MAX_SETS * MAX_WAYS;
    localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
    localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    localparam logic [SET_W-1:0]     SET_LAST = SET_W'(MAX_SETS - 1);
    localparam logic [IDX_VAL_W-1:0] SET_MASK = IDX_VAL_W'(MAX_SETS - 1);
    // Reciprocal of MAX_SETS, exact for every masked index below 2**IDX_VAL_W.
    localparam int          MOD_SH    = IDX_VAL_W + SET_W;
    localparam logic [31:0] MOD_RECIP =
        32'(((64'd1 << MOD_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

    // Configuration registers
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] index_bits_reg;
    logic [CFG_DATA_W-1:0] ways_in_use_reg;

    // Sequencer and datapath registers
    state_t                state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     line_reg, line_next;
    logic [IDX_VAL_W-1:0]  rem_reg, rem_next;
    logic [IDX_VAL_W-1:0]  quot_reg, quot_next;
    logic                  step_reg, step_next;
    logic [WAY_W-1:0]      way_reg, way_next;
    logic [WAY_W-1:0]      victim_reg, victim_next;
    logic [SETW_W-1:0]     set_new_reg, set_new_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [31:0]           hit_counter_reg, hit_counter_next;
    logic [31:0]           miss_counter_reg, miss_counter_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_out_reg, hit_out_next;
    logic [SET_W-1:0]      set_out_reg, set_out_next;
    logic [WAY_W-1:0]      way_out_reg, way_out_next;
    logic                  ev_valid_out_reg, ev_valid_out_next;
    logic [ADDR_W-1:0]     ev_line_out_reg, ev_line_out_next;

    // Memory ports
    logic                  tag_rd_en, tag_wr_en;
    logic [WAY_W-1:0]      tag_way;
    logic [TAG_AW-1:0]     tag_addr;
    logic [ADDR_W-1:0]     tag_rd_data;
    logic                  set_rd_en, set_wr_en;
    logic [SET_W-1:0]      set_wr_addr;
    logic [SETW_W-1:0]     set_wr_data;
    logic [SETW_W-1:0]     set_rd_data;

    // Shared comparator
    logic [ADDR_W-1:0]     cmp_a, cmp_b, cmp_diff;
    cmp_flags_t            cmp_flags;

    // Derived control
    logic [SET_W-1:0]      set_cur;
    logic [WAYC_W-1:0]     eff_ways;
    logic [WAYC_W-1:0]     fill_cur;
    logic [WAY_W-1:0]      oldest_cur;
    logic [WAY_W-1:0]      victim_sel;
    logic [WAY_W-1:0]      fifo_way;
    logic [WAYC_W-1:0]     fill_new;
    logic [WAY_W-1:0]      oldest_new;
    logic                  hit_now;
    logic                  last_way;
    logic                  out_free;
    logic [ADDR_W-1:0]     line_shift;
    logic [IDX_VAL_W-1:0]  idx_masked;
    logic [IDX_VAL_W:0]    idx_mask;
    logic [SET_W+7:0]      set_ext;
    logic [WAY_W+2:0]      way_ext;
    logic [31:0]           mod_prod;
    logic [31:0]           mod_quot;
    logic [31:0]           mod_back;

    assign set_cur  = rem_reg[SET_W-1:0];
    assign out_free = ~out_valid_reg | out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Clamp the associativity in use to 1..MAX_WAYS.
    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            eff_ways = WAYC_W'(1);
        end
        else if (32'(ways_in_use_reg) > MAX_WAYS)
        begin
            eff_ways = WAYC_W'(MAX_WAYS);
        end
        else
        begin
            eff_ways = WAYC_W'(ways_in_use_reg);
        end
    end

    // Line number and masked index
    assign line_shift = addr_reg >> offset_bits_reg;
    assign idx_mask   = (IDX_VAL_W + 1)'(1) << index_bits_reg;
    assign idx_masked = line_shift[IDX_VAL_W-1:0] & (idx_mask[IDX_VAL_W-1:0] - 1'b1);

    // Set reduction for a MAX_SETS that is not a power of two: quotient first,
    // then the product that the comparator takes off the index.
    assign mod_prod = 32'(rem_reg) * MOD_RECIP;
    assign mod_quot = mod_prod >> MOD_SH;
    assign mod_back = 32'(quot_reg) * 32'(MAX_SETS);

    // Set state word: fill count above, FIFO pointer below.
    assign fill_cur   = set_rd_data[SETW_W-1:WAY_W];
    assign oldest_cur = set_rd_data[WAY_W-1:0];

    // Victim choice: next empty way, else the oldest way (restart past the ways in use).
    always_comb
    begin
        fifo_way = (WAYC_W'(oldest_cur) >= eff_ways) ? '0 : oldest_cur;
        if (fill_cur < eff_ways)
        begin
            victim_sel = WAY_W'(fill_cur);
            fill_new   = fill_cur + 1'b1;
            oldest_new = oldest_cur;
        end
        else
        begin
            victim_sel = fifo_way;
            fill_new   = fill_cur;
            oldest_new = ((WAYC_W'(fifo_way) + 1'b1) >= eff_ways) ? '0
                                                                  : WAY_W'(fifo_way + 1'b1);
        end
    end

    assign hit_now  = (WAYC_W'(way_reg) < fill_cur) & cmp_flags.eq;
    assign last_way = (WAYC_W'(way_reg) + 1'b1) >= eff_ways;
    assign tag_addr = TAG_AW'(32'(set_cur) * 32'(MAX_WAYS) + 32'(tag_way));

    sacf_cmp_unit #(
        .W (ADDR_W)
    ) u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .flags (cmp_flags),
        .diff  (cmp_diff)
    );

    sacf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TAG_DEPTH),
        .AW    (TAG_AW)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_addr),
        .wr_data (line_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_addr),
        .rd_data (tag_rd_data)
    );

    sacf_ram #(
        .WIDTH (SETW_W),
        .DEPTH (MAX_SETS),
        .AW    (SET_W)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (set_wr_en),
        .wr_addr (set_wr_addr),
        .wr_data (set_wr_data),
        .rd_en   (set_rd_en),
        .rd_addr (set_cur),
        .rd_data (set_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = SETS_POW2 ? ST_SETRD : ST_MOD;
            end
            ST_MOD:
            begin
                if (step_reg == 1'b1)
                begin
                    state_next = ST_SETRD;
                end
            end
            ST_SETRD:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (hit_now)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (last_way)
                begin
                    state_next = ST_VICTIM;
                end
            end
            ST_VICTIM:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output register
    always_comb
    begin
        clr_cnt_next      = clr_cnt_reg;
        addr_next         = addr_reg;
        line_next         = line_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        step_next         = step_reg;
        way_next          = way_reg;
        victim_next       = victim_reg;
        set_new_next      = set_new_reg;
        ev_valid_next     = ev_valid_reg;
        hit_counter_next  = hit_counter_reg;
        miss_counter_next = miss_counter_reg;
        out_valid_next    = out_valid_reg & ~out_ready;
        hit_out_next      = hit_out_reg;
        set_out_next      = set_out_reg;
        way_out_next      = way_out_reg;
        ev_valid_out_next = ev_valid_out_reg;
        ev_line_out_next  = ev_line_out_reg;
        tag_rd_en         = 1'b0;
        tag_wr_en         = 1'b0;
        tag_way           = way_reg;
        set_rd_en         = 1'b0;
        set_wr_en         = 1'b0;
        set_wr_addr       = set_cur;
        set_wr_data       = set_new_reg;
        cmp_a             = tag_rd_data;
        cmp_b             = line_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                set_wr_en    = 1'b1;
                set_wr_addr  = clr_cnt_reg;
                set_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = address;
                end
            end
            ST_SHIFT:
            begin
                line_next = line_shift;
                rem_next  = SETS_POW2 ? (idx_masked & SET_MASK) : idx_masked;
                step_next = 1'b0;
            end
            ST_MOD:
            begin
                if (step_reg == 1'b0)
                begin
                    // Hold the quotient of the masked index by MAX_SETS.
                    quot_next = mod_quot[IDX_VAL_W-1:0];
                    step_next = 1'b1;
                end
                else
                begin
                    // Drop quotient times MAX_SETS to leave the set.
                    cmp_a    = ADDR_W'(rem_reg);
                    cmp_b    = mod_back;
                    rem_next = cmp_flags.ge ? cmp_diff[IDX_VAL_W-1:0] : rem_reg;
                end
            end
            ST_SETRD:
            begin
                set_rd_en = 1'b1;
                tag_rd_en = 1'b1;
                tag_way   = '0;
                way_next  = '0;
            end
            ST_SEARCH:
            begin
                if (hit_now)
                begin
                    if (out_free)
                    begin
                        hit_counter_next  = (&hit_counter_reg) ? hit_counter_reg
                                                               : hit_counter_reg + 1'b1;
                        out_valid_next    = 1'b1;
                        hit_out_next      = 1'b1;
                        set_out_next      = set_cur;
                        way_out_next      = way_reg;
                        ev_valid_out_next = 1'b0;
                        ev_line_out_next  = '0;
                    end
                end
                else if (!last_way)
                begin
                    way_next  = WAY_W'(way_reg + 1'b1);
                    tag_way   = WAY_W'(way_reg + 1'b1);
                    tag_rd_en = 1'b1;
                end
            end
            ST_VICTIM:
            begin
                tag_way       = victim_sel;
                tag_rd_en     = 1'b1;
                victim_next   = victim_sel;
                set_new_next  = {fill_new, oldest_new};
                ev_valid_next = WAYC_W'(victim_sel) < fill_cur;
            end
            ST_WRITE:
            begin
                tag_way = victim_reg;
                if (out_free)
                begin
                    tag_wr_en         = 1'b1;
                    set_wr_en         = 1'b1;
                    miss_counter_next = (&miss_counter_reg) ? miss_counter_reg
                                                            : miss_counter_reg + 1'b1;
                    out_valid_next    = 1'b1;
                    hit_out_next      = 1'b0;
                    set_out_next      = set_cur;
                    way_out_next      = victim_reg;
                    ev_valid_out_next = ev_valid_reg;
                    ev_line_out_next  = ev_valid_reg ? tag_rd_data : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            hit_counter_reg  <= '0;
            miss_counter_reg <= '0;
            out_valid_reg    <= 1'b0;
            offset_bits_reg  <= OFFSET_BITS_RST;
            index_bits_reg   <= INDEX_BITS_RST;
            ways_in_use_reg  <= WAYS_IN_USE_RST;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            hit_counter_reg  <= hit_counter_next;
            miss_counter_reg <= miss_counter_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                    CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        line_reg         <= line_next;
        rem_reg          <= rem_next;
        quot_reg         <= quot_next;
        step_reg         <= step_next;
        way_reg          <= way_next;
        victim_reg       <= victim_next;
        set_new_reg      <= set_new_next;
        ev_valid_reg     <= ev_valid_next;
        hit_out_reg      <= hit_out_next;
        set_out_reg      <= set_out_next;
        way_out_reg      <= way_out_next;
        ev_valid_out_reg <= ev_valid_out_next;
        ev_line_out_reg  <= ev_line_out_next;
    end

    // Outputs: set and way are reported in their low 8 and 3 bits.
    assign set_ext       = {8'b0, set_out_reg};
    assign way_ext       = {3'b0, way_out_reg};
    assign out_valid     = out_valid_reg;
    assign hit           = hit_out_reg;
    assign set_number    = set_ext[7:0];
    assign way_number    = way_ext[2:0];
    assign evicted_valid = ev_valid_out_reg;
    assign evicted_line  = ev_line_out_reg;
    assign hit_total     = hit_counter_reg;
    assign miss_total    = miss_counter_reg;

`ifndef SYNTHESIS
    // A hit never reports a replaced line.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_out_reg |-> !ev_valid_out_reg && ev_line_out_reg == '0)
        else $error("hit word carries an evicted line");

    // An accepted address blocks the input until the lookup ends.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a lookup is in flight");

    // Counts only move up, and only one of them per result.
    a_counts_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        hit_counter_reg >= $past(hit_counter_reg)
        && miss_counter_reg >= $past(miss_counter_reg)
        && !(hit_counter_reg != $past(hit_counter_reg)
             && miss_counter_reg != $past(miss_counter_reg)))
        else $error("hit/miss counts moved wrongly");
`endif

endmodule

[test/tb_set_assoc_cache_fifo_lookup_unit.sv]
// Self-checking bench for set_assoc_cache_fifo_lookup_unit: FIFO-replacement tag store.
// Depends on sacf_pkg and the block's RTL; predicts every lookup word in a scoreboard class.
// Stimulus is a directed opening, then random phases under changing cache geometries.
module tb_set_assoc_cache_fifo_lookup_unit;

    import sacf_pkg::*;

    localparam int SET_COUNT   = MAX_SETS_DEF;
    localparam int WAY_COUNT   = MAX_WAYS_DEF;
    localparam int MAX_REPORTS = 10;
    localparam int QUIET_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_CYCLES = 30;

    // One result word of the lookup channel.
    typedef struct {
        logic        hit;
        logic [7:0]  set_number;
        logic [2:0]  way_number;
        logic        evicted_valid;
        logic [31:0] evicted_line;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } lookup_word_t;

    // Scoreboard: keeps its own copy of the tag store and geometry, predicts each
    // lookup when its address is accepted and matches result words in order.
    class lookup_checker;
        logic [CFG_DATA_W-1:0] offset_cfg;
        logic [CFG_DATA_W-1:0] index_cfg;
        logic [CFG_DATA_W-1:0] ways_cfg;
        logic [31:0]           line_tag [SET_COUNT][WAY_COUNT];
        bit                    line_ok  [SET_COUNT][WAY_COUNT];
        int unsigned           fill_count [SET_COUNT];
        int unsigned           fifo_ptr   [SET_COUNT];
        logic [31:0]           hit_count;
        logic [31:0]           miss_count;
        lookup_word_t          pending_lookups [$];
        int unsigned           error_count;
        int unsigned           words_checked;
        int unsigned           evictions;

        function new();
            offset_cfg = OFFSET_BITS_RST;
            index_cfg  = INDEX_BITS_RST;
            ways_cfg   = WAYS_IN_USE_RST;
            foreach (line_tag[s, w])
            begin
                line_tag[s][w] = '0;
                line_ok[s][w]  = 1'b0;
            end
            foreach (fill_count[s])
            begin
                fill_count[s] = 0;
                fifo_ptr[s]   = 0;
            end
            hit_count     = '0;
            miss_count    = '0;
            error_count   = 0;
            words_checked = 0;
            evictions     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OFFSET_BITS: offset_cfg = val;
                CFG_INDEX_BITS:  index_cfg  = val;
                CFG_WAYS_IN_USE: ways_cfg   = val;
                default: ;
            endcase
        endfunction

        function lookup_word_t predict_lookup(logic [31:0] addr);
            lookup_word_t r;
            logic [31:0]  line_num;
            logic [31:0]  mask;
            int unsigned  set_idx;
            int unsigned  ways;
            int unsigned  way;
            bit           found;
            line_num = addr >> offset_cfg;
            mask     = (32'd1 << index_cfg) - 32'd1;
            set_idx  = (line_num & mask) % SET_COUNT;
            ways     = (ways_cfg == 0) ? 1 : (ways_cfg > WAY_COUNT) ? WAY_COUNT : ways_cfg;
            found    = 1'b0;
            way      = 0;
            r.evicted_valid = 1'b0;
            r.evicted_line  = '0;
            for (int w = 0; w < ways && !found; w++)
            begin
                if (line_ok[set_idx][w] && line_tag[set_idx][w] == line_num)
                begin
                    found = 1'b1;
                    way   = w;
                end
            end
            if (found)
            begin
                if (hit_count != 32'hFFFF_FFFF)
                    hit_count++;
            end
            else
            begin
                if (miss_count != 32'hFFFF_FFFF)
                    miss_count++;
                // Fill empty ways first, then rotate through the oldest.
                if (fill_count[set_idx] < ways)
                begin
                    way = fill_count[set_idx];
                    fill_count[set_idx]++;
                end
                else
                begin
                    way = fifo_ptr[set_idx];
                    if (way >= ways)
                        way = 0;
                    fifo_ptr[set_idx] = (way + 1 >= ways) ? 0 : way + 1;
                end
                if (line_ok[set_idx][way])
                begin
                    r.evicted_valid = 1'b1;
                    r.evicted_line  = line_tag[set_idx][way];
                    evictions++;
                end
                line_tag[set_idx][way] = line_num;
                line_ok[set_idx][way]  = 1'b1;
            end
            r.hit        = found;
            r.set_number = set_idx[7:0];
            r.way_number = way[2:0];
            r.hit_total  = hit_count;
            r.miss_total = miss_count;
            return r;
        endfunction

        function void note_address(logic [31:0] addr);
            pending_lookups.insert(pending_lookups.size(), predict_lookup(addr));
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_word(lookup_word_t got);
            lookup_word_t want;
            if (pending_lookups.size() == 0)
            begin
                flag($sformatf("unexpected result word: hit=%0b set=%0d way=%0d",
                               got.hit, got.set_number, got.way_number));
                return;
            end
            want = pending_lookups[0];
            pending_lookups.delete(0);
            words_checked++;
            if (got.hit !== want.hit || got.set_number !== want.set_number ||
                got.way_number !== want.way_number ||
                got.evicted_valid !== want.evicted_valid ||
                got.evicted_line !== want.evicted_line ||
                got.hit_total !== want.hit_total || got.miss_total !== want.miss_total)
                flag($sformatf({"word %0d mismatch: expected hit=%0b set=%0d way=%0d ev=%0b/%08h",
                                " totals=%0d/%0d; got hit=%0b set=%0d way=%0d ev=%0b/%08h",
                                " totals=%0d/%0d"},
                               words_checked, want.hit, want.set_number, want.way_number,
                               want.evicted_valid, want.evicted_line, want.hit_total,
                               want.miss_total, got.hit, got.set_number, got.way_number,
                               got.evicted_valid, got.evicted_line, got.hit_total,
                               got.miss_total));
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ADDR_W-1:0]     address;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [7:0]            set_number;
    logic [2:0]            way_number;
    logic                  evicted_valid;
    logic [ADDR_W-1:0]     evicted_line;
    logic [31:0]           hit_total;
    logic [31:0]           miss_total;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lookup_checker         sb;

    // Geometry currently programmed, mirrored for address generation.
    logic [3:0]            geo_offset;
    logic [3:0]            geo_index;
    logic [3:0]            geo_ways;
    int unsigned           geometries;

    // Traffic shaping state.
    int                    burst_left;
    bit                    tx_steady;
    bit                    rx_steady;
    bit                    rx_open;
    int                    rx_left;
    int unsigned           quiet_cycles;
    int unsigned           random_sent;

    // Addresses of the current phase are drawn mostly from this pool of lines.
    logic [31:0]           line_pool [$];

    // Extreme geometries visited by the first random phases: offset, index, ways.
    logic [3:0]            corner_geo [5][3] = '{'{4'd12, 4'd8,  4'd8},
                                                 '{4'd0,  4'd0,  4'd1},
                                                 '{4'd15, 4'd15, 4'd15},
                                                 '{4'd13, 4'd9,  4'd0},
                                                 '{4'd3,  4'd8,  4'd9}};

    set_assoc_cache_fifo_lookup_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .set_number    (set_number),
        .way_number    (way_number),
        .evicted_valid (evicted_valid),
        .evicted_line  (evicted_line),
        .hit_total     (hit_total),
        .miss_total    (miss_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: accept all the time, or alternate ready runs with stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_steady)
            out_ready <= 1'b1;
        else
        begin
            if (rx_left <= 0)
            begin
                rx_open = !rx_open;
                rx_left = rx_open ? $urandom_range(1, 25) : $urandom_range(1, 12);
            end
            rx_left--;
            out_ready <= rx_open;
        end
    end

    // Monitor and watchdog: sample both handshakes at the rising edge, note the
    // address before checking a word, and count edges on which nothing moves.
    always @(posedge clk)
    begin
        lookup_word_t seen;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                sb.note_address(address);
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                seen.hit           = hit;
                seen.set_number    = set_number;
                seen.way_number    = way_number;
                seen.evicted_valid = evicted_valid;
                seen.evicted_line  = evicted_line;
                seen.hit_total     = hit_total;
                seen.miss_total    = miss_total;
                sb.check_word(seen);
                moved = 1'b1;
            end
        end
        else
            moved = 1'b0;
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     QUIET_LIMIT, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Write one register; drop the enable on the following falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Program all three registers; only call with the block drained.
    task automatic set_geometry(input logic [3:0] offs, input logic [3:0] idx,
                                input logic [3:0] ways);
        write_reg(CFG_OFFSET_BITS, offs);
        write_reg(CFG_INDEX_BITS, idx);
        write_reg(CFG_WAYS_IN_USE, ways);
        geo_offset = offs;
        geo_index  = idx;
        geo_ways   = ways;
        geometries++;
    endtask

    // Present one address and hold it until taken; close the burst with a gap.
    task automatic send_address(input logic [31:0] addr);
        int gap;
        if (burst_left <= 0)
            burst_left = tx_steady ? 100000 : $urandom_range(1, 40);
        @(negedge clk);
        in_valid <= 1'b1;
        address  <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid right after the last accepted word and wait for every result.
    task automatic close_phase();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Build a pool of lines, mostly crowded into at most four sets, so that hits and evictions occur.
    task automatic build_pool();
        logic [31:0] mask;
        logic [31:0] ln;
        int          span;
        int          count;
        mask  = (32'd1 << geo_index) - 32'd1;
        span  = ($urandom_range(0, 3) == 0) ? SET_COUNT : $urandom_range(1, 4);
        count = $urandom_range(2, 40);
        line_pool.delete();
        repeat (count)
        begin
            ln = $urandom;
            ln = (ln & ~mask) | ($urandom_range(0, span - 1) & mask);
            line_pool.insert(line_pool.size(), ln & (32'hFFFF_FFFF >> geo_offset));
        end
    endtask

    function automatic logic [31:0] pick_address();
        logic [31:0] ln;
        logic [31:0] low;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        ln  = line_pool[$urandom_range(0, line_pool.size() - 1)];
        low = $urandom & ((32'd1 << geo_offset) - 32'd1);
        return (ln << geo_offset) | low;
    endfunction

    initial
    begin
        int          phase;
        int          count;
        logic [3:0]  offs;
        logic [3:0]  idx;
        logic [3:0]  ways;

        in_valid     = 1'b0;
        address      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_OFFSET_BITS;
        cfg_data     = '0;
        rst_n        = 1'b0;
        rx_steady    = 1'b0;
        tx_steady    = 1'b0;
        rx_open      = 1'b0;
        rx_left      = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        random_sent  = 0;
        geometries   = 1;
        geo_offset   = OFFSET_BITS_RST;
        geo_index    = INDEX_BITS_RST;
        geo_ways     = WAYS_IN_USE_RST;
        sb = new();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry (16-byte lines, 16 sets, 2 ways): empty-way fills, a
        // repeat hit, a full set forcing FIFO eviction, all-ones and all-zeros.
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_0100);
        send_address(32'h0000_0200);
        send_address(32'h0000_000F);
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        close_phase();

        // Offset and index beyond their ranges, ways of zero acting as one.
        set_geometry(4'd15, 4'd15, 4'd0);
        send_address(32'hFFFF_8000);
        send_address(32'h0000_8000);
        send_address(32'h7FFF_0000);
        close_phase();

        // One set, four ways: fill, evict three times to move the FIFO pointer.
        set_geometry(4'd0, 4'd0, 4'd4);
        for (int a = 1; a <= 7; a++)
            send_address(a);
        close_phase();

        // Shrink to two ways: the pointer restarts at way 0 and the line held in
        // way 2 falls outside the search.
        set_geometry(4'd0, 4'd0, 4'd2);
        send_address(32'd8);
        send_address(32'd3);
        close_phase();

        // Random phases, corner geometries first.
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase < 5)
            begin
                offs = corner_geo[phase][0];
                idx  = corner_geo[phase][1];
                ways = corner_geo[phase][2];
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                offs = $urandom_range(0, 15);
                idx  = $urandom_range(0, 15);
                ways = $urandom_range(0, 15);
            end
            else
            begin
                offs = $urandom_range(0, 12);
                idx  = $urandom_range(0, 8);
                ways = $urandom_range(1, 8);
            end
            set_geometry(offs, idx, ways);
            build_pool();
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            count = $urandom_range(80, 200);
            if (random_sent + count > RANDOM_ITEMS)
                count = RANDOM_ITEMS - random_sent;
            repeat (count)
                send_address(pick_address());
            random_sent += count;
            close_phase();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d lookups under %0d cache geometries: %0d hits, %0d misses,",
                 sb.words_checked, geometries, sb.hit_count, sb.miss_count);
        $display("%0d evictions, %0d mismatches.", sb.evictions, sb.error_count);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
